// ----- design/ctvf_pkg.sv -----
// Shared types and constants for the call-trace vtable filter.
// Used by every module of the block except ctvf_ram; depends on nothing.
`timescale 1ns / 1ps

package ctvf_pkg;

    // Range table geometry and pointer size
    localparam int RANGE_DEPTH   = 64;
    localparam int IDX_W         = $clog2(RANGE_DEPTH);
    localparam int NCNT_W        = IDX_W + 1;
    localparam int SRCH_W        = IDX_W + 2;
    localparam int POINTER_BYTES = 8;
    localparam int ALIGN_W       = $clog2(POINTER_BYTES);

    // Field widths
    localparam int ADDR_W   = 64;
    localparam int SLOT_W   = 6;
    localparam int OFS_W    = 32;
    localparam int RCOUNT_W = 7;
    localparam int SKIP_W   = 8;
    localparam int EVCNT_W  = 32;
    localparam int ENTRY_W  = 2 * ADDR_W;

    // Input tdata layout, lowest field first
    localparam int LOC_LSB   = 0;
    localparam int TGT_LSB   = LOC_LSB + ADDR_W;
    localparam int PTR_LSB   = TGT_LSB + ADDR_W;
    localparam int VT_LSB    = PTR_LSB + ADDR_W;
    localparam int SLOT_LSB  = VT_LSB + ADDR_W;
    localparam int FIRST_LSB = SLOT_LSB + SLOT_W;
    localparam int LIMIT_LSB = FIRST_LSB + ADDR_W;
    localparam int S_BITS    = LIMIT_LSB + ADDR_W;
    localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 3 * OFS_W;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_ADDR_W-1:0] REG_MODULE_START = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MODULE_END   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_COUNT  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SKIP_MASK    = 2'd3;

    // Item kinds carried in s_tuser
    localparam logic OP_CALL = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EVAL,
        ST_ADDR,
        ST_CMP,
        ST_OUT
    } ctvf_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic ram_we;
        logic cnt_step;
        logic srch_init;
        logic srch_issue;
        logic srch_update;
        logic out_load;
    } ctvf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op;
        logic prefilter_ok;
        logic srch_active;
        logic hit;
        logic out_free;
    } ctvf_sts_t;

endpackage

// ----- design/ctvf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package dependency.
`timescale 1ns / 1ps

module ctvf_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/ctvf_datapath.sv -----
// Datapath: item capture, configuration registers, event counter, range table,
// binary-search bounds and output register. Depends on ctvf_pkg and ctvf_ram.
`timescale 1ns / 1ps

module ctvf_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ctvf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ctvf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [ctvf_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [ctvf_pkg::M_TDATA_W-1:0]    m_tdata,
    input  ctvf_pkg::ctvf_cmd_t               cmd,
    output ctvf_pkg::ctvf_sts_t               sts
);
    import ctvf_pkg::*;

    // Captured transaction
    logic                op_reg;
    logic [ADDR_W-1:0]   loc_reg;
    logic [ADDR_W-1:0]   tgt_reg;
    logic [ADDR_W-1:0]   ptr_reg;
    logic [ADDR_W-1:0]   vt_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ADDR_W-1:0]   first_reg;
    logic [ADDR_W-1:0]   limit_reg;

    // Configuration and counter
    logic [ADDR_W-1:0]   module_start_reg;
    logic [ADDR_W-1:0]   module_end_reg;
    logic [RCOUNT_W-1:0] range_count_reg;
    logic [SKIP_W-1:0]   skip_mask_reg;
    logic [EVCNT_W-1:0]  event_counter_reg;

    // Search bounds
    logic signed [SRCH_W-1:0] lo_reg;
    logic signed [SRCH_W-1:0] hi_reg;
    logic [IDX_W-1:0]         mid_reg;
    logic [IDX_W-1:0]         mid_next;
    logic signed [SRCH_W-1:0] bound_sum;
    logic signed [SRCH_W-1:0] mid_ext;
    logic [NCNT_W-1:0]        n_eff;

    // Output register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // Table access
    logic               slot_ok;
    logic [ENTRY_W-1:0] rd_data;
    logic [ADDR_W-1:0]  rd_low;
    logic [ADDR_W-1:0]  rd_high;
    logic               lt_low;
    logic               ge_high;

    // Prefilter terms
    logic skip_ok;
    logic tgt_in;
    logic vt_in;
    logic aligned;

    // Capture the accepted transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_tuser;
            loc_reg   <= s_tdata[LOC_LSB +: ADDR_W];
            tgt_reg   <= s_tdata[TGT_LSB +: ADDR_W];
            ptr_reg   <= s_tdata[PTR_LSB +: ADDR_W];
            vt_reg    <= s_tdata[VT_LSB +: ADDR_W];
            slot_reg  <= s_tdata[SLOT_LSB +: SLOT_W];
            first_reg <= s_tdata[FIRST_LSB +: ADDR_W];
            limit_reg <= s_tdata[LIMIT_LSB +: ADDR_W];
        end
    end

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            module_start_reg <= '0;
            module_end_reg   <= '0;
            range_count_reg  <= '0;
            skip_mask_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MODULE_START: module_start_reg <= cfg_wdata;
                REG_MODULE_END:   module_end_reg   <= cfg_wdata;
                REG_RANGE_COUNT:  range_count_reg  <= cfg_wdata[RCOUNT_W-1:0];
                REG_SKIP_MASK:    skip_mask_reg    <= cfg_wdata[SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the free-running event counter once per call event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            event_counter_reg <= '0;
        end else if (cmd.cnt_step) begin
            event_counter_reg <= event_counter_reg + EVCNT_W'(1);
        end
    end

    // Range table: low bound in the lower half, exclusive high bound above
    assign slot_ok = (int'(slot_reg) < RANGE_DEPTH);
    assign rd_low  = rd_data[ADDR_W-1:0];
    assign rd_high = rd_data[ENTRY_W-1:ADDR_W];

    ctvf_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(RANGE_DEPTH)
    ) u_range_ram (
        .aclk  (aclk),
        .we    (cmd.ram_we && slot_ok),
        .waddr (slot_reg[IDX_W-1:0]),
        .wdata ({limit_reg, first_reg}),
        .re    (cmd.srch_issue),
        .raddr (mid_next),
        .rdata (rd_data)
    );

    // Prefilter on the old counter value and the module bounds
    assign skip_ok = ((event_counter_reg[SKIP_W-1:0] & skip_mask_reg) == '0);
    assign tgt_in  = (tgt_reg >= module_start_reg) && (tgt_reg <= module_end_reg);
    assign vt_in   = (vt_reg >= module_start_reg) && (vt_reg <= module_end_reg);
    assign aligned = (ptr_reg[ALIGN_W-1:0] == '0);

    // Searched entries: count clipped to the table depth
    assign n_eff = (int'(range_count_reg) > RANGE_DEPTH) ? NCNT_W'(RANGE_DEPTH)
                                                         : NCNT_W'(range_count_reg);

    // Midpoint of the live bounds; both are non-negative while the search runs
    assign bound_sum = lo_reg + hi_reg;
    assign mid_next  = bound_sum[IDX_W:1];
    assign mid_ext   = $signed(SRCH_W'(mid_reg));

    // Compare the pointer against the entry just read
    assign lt_low  = (ptr_reg < rd_low);
    assign ge_high = (ptr_reg >= rd_high);

    // Hold and narrow the search bounds
    always_ff @(posedge aclk) begin
        if (cmd.srch_init) begin
            lo_reg <= '0;
            hi_reg <= $signed(SRCH_W'(n_eff)) - SRCH_W'(1);
        end else if (cmd.srch_update) begin
            if (lt_low) begin
                hi_reg <= mid_ext - SRCH_W'(1);
            end else if (ge_high) begin
                lo_reg <= mid_ext + SRCH_W'(1);
            end
        end
        if (cmd.srch_issue) begin
            mid_reg <= mid_next;
        end
    end

    // Output register: load offsets, drop valid once the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {vt_reg[OFS_W-1:0] - module_start_reg[OFS_W-1:0],
                             tgt_reg[OFS_W-1:0] - module_start_reg[OFS_W-1:0],
                             loc_reg[OFS_W-1:0] - module_start_reg[OFS_W-1:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status back to the controller
    always_comb begin
        sts.op           = op_reg;
        sts.prefilter_ok = skip_ok && tgt_in && vt_in && aligned;
        sts.srch_active  = (lo_reg <= hi_reg);
        sts.hit          = !lt_low && !ge_high;
        sts.out_free     = !out_valid_reg || m_tready;
    end

endmodule

// ----- design/ctvf_controller.sv -----
// Controller state machine: sequences loads, prefilter, binary search and
// hand-off to the output register. Depends on ctvf_pkg.
`timescale 1ns / 1ps

module ctvf_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ctvf_pkg::ctvf_sts_t sts,
    output ctvf_pkg::ctvf_cmd_t cmd
);
    import ctvf_pkg::*;

    ctvf_state_t state_reg;
    ctvf_state_t state_next;
    logic        accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.op == OP_LOAD) begin
                    state_next = ST_LOAD;
                end else if (sts.prefilter_ok) begin
                    state_next = ST_ADDR;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD: begin
                state_next = ST_IDLE;
            end
            ST_ADDR: begin
                if (sts.srch_active) begin
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMP: begin
                if (sts.hit) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_ADDR;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.capture = accept;
            end
            ST_EVAL: begin
                cmd.cnt_step  = (sts.op == OP_CALL);
                cmd.srch_init = (sts.op == OP_CALL);
            end
            ST_LOAD: begin
                cmd.ram_we = 1'b1;
            end
            ST_ADDR: begin
                cmd.srch_issue = sts.srch_active;
            end
            ST_CMP: begin
                cmd.srch_update = 1'b1;
            end
            ST_OUT: begin
                cmd.out_load = sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ----- design/call_trace_vtable_filter_top.sv -----
// Top level of the call-trace vtable filter: controller plus datapath.
// Depends on ctvf_pkg, ctvf_controller, ctvf_datapath and ctvf_ram.
`timescale 1ns / 1ps

// One item is worked on at a time. A load item (s_tuser = 1) goes through
// accept, decode and table write. A call event (s_tuser = 0) ends after decode
// when the skip mask, module bounds or alignment reject it; otherwise the binary
// search over min(range_count, 64) entries runs up to 7 steps, each an address
// state, then a compare against the registered read of the range table, and a
// hit then loads the output register once it is free; that load waits for as
// long as an earlier result still stalls on m_tready. The output register
// decouples the sides: a new item is accepted while a result still waits on
// m_tready. The range table has no reset; entries must be loaded before a
// search can reach them.

module call_trace_vtable_filter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [ctvf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ctvf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, lowest bit up: call_location[63:0], call_target[127:64],
    // object_pointer[191:128], vtable_word[255:192], range_slot[261:256],
    // range_first[325:262], range_limit[389:326], zero pad[391:390]
    input  logic [ctvf_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: op (0 = call event, 1 = load range entry)
    input  logic                              s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, lowest bit up: origin_offset[31:0], target_offset[63:32],
    // vtable_offset[95:64]
    output logic [ctvf_pkg::M_TDATA_W-1:0]    m_tdata
);
    import ctvf_pkg::*;

    ctvf_cmd_t cmd;
    ctvf_sts_t sts;

    ctvf_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ctvf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- design/ctvf_checker.sv -----
// Port-level checker for the call-trace vtable filter, bound to the top level.
// Depends on ctvf_pkg.
`timescale 1ns / 1ps

module ctvf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ctvf_pkg::M_TDATA_W-1:0] m_tdata
);
    import ctvf_pkg::*;

    // Hold a stalled result unchanged
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Output register is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Block is ready for a transaction after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // One item at a time: the input is closed in the cycle after an accepted transaction
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

endmodule

bind call_trace_vtable_filter_top ctvf_checker u_ctvf_checker (.*);
